/* src/gia_pkg.sv */
// shared types and constants for the generational id allocator
package gia_pkg;

  // request kind carried on mode
  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  localparam int unsigned HandleW  = 32;
  localparam int unsigned TypeInW  = 8;
  localparam int unsigned SlotOutW = 10;
  localparam int unsigned AvatarW  = 11;
  localparam logic [AvatarW-1:0] AvatarMax = {AvatarW{1'b1}};

endpackage

/* src/gia_ram.sv */
// generic simple dual-port ram with registered read
module gia_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* src/generational_id_allocator_unit.sv */
// top level of the generational id allocator with a fifo free pool
//
//  channel   | ports                                        | direction | flow
//  ----------+----------------------------------------------+-----------+---------------
//  request   | start, busy, mode_i, actor_type_i,           | in        | start & !busy
//            | is_avatar_i, handle_in_i                     |           |
//  result    | done_o, handle_out_o, slot_index_o,          | out       | done_o pulse
//            | status_o, avatar_total_o, highest_slot_o     |           |
//
// each word is accepted in idle and handled in exec: the accept cycle issues the pool read at the
// head, the next cycle (busy high) combines the read data and writes a freed
// id back at the tail; the registered read of the pool ram sets this split;
// the result shows on done_o in the cycle after that, and a new word may be
// accepted in that same cycle
// after reset the pool needs no clearing pass: a position the tail has not yet
// reached reads as its reset id (index = position, generation zero)
// the receiver cannot stall; every result is taken in the cycle it is shown
module generational_id_allocator_unit
  import gia_pkg::*;
#(
  parameter int unsigned SLOTS      = 1024,
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned GEN_BITS   = 14,
  parameter int unsigned TYPE_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                mode_i,
  input  logic [TypeInW-1:0]  actor_type_i,
  input  logic                is_avatar_i,
  input  logic [HandleW-1:0]  handle_in_i,
  output logic                done_o,
  output logic [HandleW-1:0]  handle_out_o,
  output logic [SlotOutW-1:0] slot_index_o,
  output logic [1:0]          status_o,
  output logic [AvatarW-1:0]  avatar_total_o,
  output logic [SlotOutW-1:0] highest_slot_o
);

  localparam int unsigned PtrW    = $clog2(SLOTS);
  localparam int unsigned CntW    = $clog2(SLOTS + 1);
  localparam int unsigned EntryW  = INDEX_BITS + GEN_BITS;
  localparam int unsigned FullW   = EntryW + TYPE_BITS;
  localparam logic [PtrW-1:0] LastPos  = PtrW'(SLOTS - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(SLOTS);

  // control state
  state_e                state_q, state_d;
  logic [PtrW-1:0]       head_q, head_d;
  logic [PtrW-1:0]       tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  wrapped_q, wrapped_d;   // tail has passed every position
  logic [AvatarW-1:0]    avatar_q, avatar_d;
  logic [INDEX_BITS-1:0] max_slot_q, max_slot_d;
  logic                  done_q;

  // captured request word
  logic                  mode_q;
  logic [TypeInW-1:0]    actor_type_q;
  logic                  is_avatar_q;
  logic [HandleW-1:0]    handle_in_q;

  // result payload
  logic [HandleW-1:0]    handle_q, handle_d;
  logic [SlotOutW-1:0]   slot_q, slot_d;
  status_e               status_q, status_d;

  // pool ram
  logic                  accept;
  logic                  ram_we;
  logic [EntryW-1:0]     ram_wdata;
  logic [EntryW-1:0]     ram_rdata;

  // exec datapath
  logic                  exec;
  logic                  head_written;
  logic [EntryW-1:0]     pop_entry;
  logic [INDEX_BITS-1:0] pop_idx;
  logic [GEN_BITS-1:0]   pop_gen;
  logic [FullW-1:0]      new_handle;

  assign accept = start & ~busy;
  assign busy   = (state_q == ST_EXEC);
  assign exec   = (state_q == ST_EXEC);

  gia_ram #(
    .WIDTH (EntryW),
    .DEPTH (SLOTS)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // a position below the tail, or any position once the tail wrapped, was written
  assign head_written = wrapped_q | (head_q < tail_q);
  assign pop_entry    = head_written ? ram_rdata
                                     : {{GEN_BITS{1'b0}}, INDEX_BITS'(head_q)};
  assign pop_idx      = pop_entry[INDEX_BITS-1:0];
  assign pop_gen      = pop_entry[EntryW-1:INDEX_BITS] + GEN_BITS'(1);
  assign new_handle   = {actor_type_q[TYPE_BITS-1:0], pop_gen, pop_idx};

  // freed id keeps index and generation, type bits dropped
  assign ram_wdata = EntryW'(handle_in_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    wrapped_d  = wrapped_q;
    avatar_d   = avatar_q;
    max_slot_d = max_slot_q;
    handle_d   = '0;
    slot_d     = '0;
    status_d   = STATUS_OK;
    ram_we     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (mode_q == MODE_ALLOC) begin
          if (count_q == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            head_d   = (head_q == LastPos) ? '0 : head_q + PtrW'(1);
            count_d  = count_q - CntW'(1);
            handle_d = HandleW'(new_handle);
            slot_d   = SlotOutW'(pop_idx);
            if (pop_idx > max_slot_q) begin
              max_slot_d = pop_idx;
            end
            if (is_avatar_q && (avatar_q != AvatarMax)) begin
              avatar_d = avatar_q + AvatarW'(1);
            end
          end
        end else begin
          if (count_q == FullCnt) begin
            status_d = STATUS_FULL;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
            slot_d  = SlotOutW'(handle_in_q[INDEX_BITS-1:0]);
            if (tail_q == LastPos) begin
              tail_d    = '0;
              wrapped_d = 1'b1;
            end else begin
              tail_d = tail_q + PtrW'(1);
            end
            if (is_avatar_q && (avatar_q != '0)) begin
              avatar_d = avatar_q - AvatarW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= FullCnt;
      wrapped_q  <= 1'b0;
      avatar_q   <= '0;
      max_slot_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      wrapped_q  <= wrapped_d;
      avatar_q   <= avatar_d;
      max_slot_q <= max_slot_d;
      done_q     <= exec;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= mode_i;
      actor_type_q <= actor_type_i;
      is_avatar_q  <= is_avatar_i;
      handle_in_q  <= handle_in_i;
    end
    if (exec) begin
      handle_q <= handle_d;
      slot_q   <= slot_d;
      status_q <= status_d;
    end
  end

  assign done_o         = done_q;
  assign handle_out_o   = handle_q;
  assign slot_index_o   = slot_q;
  assign status_o       = status_q;
  assign avatar_total_o = avatar_q;
  assign highest_slot_o = SlotOutW'(max_slot_q);

endmodule

/* test/tb.sv */
// self-checking testbench for generational_id_allocator_unit
module tb;
  import gia_pkg::*;

  // one result word as the block reports it
  typedef struct packed {
    logic [HandleW-1:0]  handle;
    logic [SlotOutW-1:0] slot;
    status_e             status;
    logic [AvatarW-1:0]  avatars;
    logic [SlotOutW-1:0] highest;
  } alloc_result_t;

  localparam int unsigned PoolSlots = 1024;
  localparam int unsigned DrainLat  = 4;      // cycles to let the pipe empty at the end

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                mode_i;
  logic [TypeInW-1:0]  actor_type_i;
  logic                is_avatar_i;
  logic [HandleW-1:0]  handle_in_i;
  logic                done_o;
  logic [HandleW-1:0]  handle_out_o;
  logic [SlotOutW-1:0] slot_index_o;
  logic [1:0]          status_o;
  logic [AvatarW-1:0]  avatar_total_o;
  logic [SlotOutW-1:0] highest_slot_o;

  generational_id_allocator_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .actor_type_i   (actor_type_i),
    .is_avatar_i    (is_avatar_i),
    .handle_in_i    (handle_in_i),
    .done_o         (done_o),
    .handle_out_o   (handle_out_o),
    .slot_index_o   (slot_index_o),
    .status_o       (status_o),
    .avatar_total_o (avatar_total_o),
    .highest_slot_o (highest_slot_o)
  );

  // clock, period 12
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // shadow copy of the allocator state
  logic [23:0]         pool_mem [PoolSlots];
  logic [9:0]          pool_rd;
  logic [9:0]          pool_wr;
  int unsigned         pool_fill;
  logic [AvatarW-1:0]  avatar_tally;
  logic [SlotOutW-1:0] top_slot;

  // results still owed by the block, oldest first
  alloc_result_t owed_results[$];
  // handles handed out and not yet returned
  logic [HandleW-1:0] live_handles[$];

  int  fail_count;
  int  words_sent;
  int  seen_alloc;
  int  seen_free;
  int  seen_empty;
  int  seen_full;
  bit  gaps_on;

  // put the shadow state into its reset shape
  task automatic reset_shadow();
    for (int i = 0; i < PoolSlots; i++) begin
      pool_mem[i] = {14'd0, i[9:0]};
    end
    pool_rd      = '0;
    pool_wr      = '0;
    pool_fill    = PoolSlots;
    avatar_tally = '0;
    top_slot     = '0;
  endtask

  // work out the result of one accepted word and advance the shadow state
  function automatic alloc_result_t predict_handle(input mode_e mode, input logic [7:0] type_tag,
                                                   input logic avatar, input logic [31:0] handle);
    alloc_result_t r;
    logic [23:0]   ent;
    logic [13:0]   gen;
    r        = '0;
    r.status = STATUS_OK;
    if (mode == MODE_ALLOC) begin
      if (pool_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        ent       = pool_mem[pool_rd];
        gen       = ent[23:10] + 14'd1;   // generation wraps at its width
        pool_rd   = pool_rd + 10'd1;
        pool_fill = pool_fill - 1;
        r.handle  = {type_tag, gen, ent[9:0]};
        r.slot    = ent[9:0];
        if (ent[9:0] > top_slot) top_slot = ent[9:0];
        if (avatar && avatar_tally != AvatarMax) avatar_tally = avatar_tally + 1'b1;
      end
    end else begin
      if (pool_fill >= PoolSlots) begin
        r.status = STATUS_FULL;
      end else begin
        // foreign handles go back unchecked, type bits dropped
        pool_mem[pool_wr] = handle[23:0];
        pool_wr   = pool_wr + 10'd1;
        pool_fill = pool_fill + 1;
        r.slot    = handle[9:0];
        if (avatar && avatar_tally != '0) avatar_tally = avatar_tally - 1'b1;
      end
    end
    r.avatars = avatar_tally;
    r.highest = top_slot;
    return r;
  endfunction

  // drive one word, wait for it to be taken, and queue its expected result
  // entered and left at a falling edge; start stays high for a back-to-back word
  task automatic send_word(input mode_e mode, input logic [7:0] type_tag, input logic avatar,
                           input logic [31:0] handle, output alloc_result_t res);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        = 1'b1;
    mode_i       = mode;
    actor_type_i = type_tag;
    is_avatar_i  = avatar;
    handle_in_i  = handle;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    res = predict_handle(mode, type_tag, avatar, handle);
    owed_results.insert(owed_results.size(), res);
    words_sent++;
    if (mode == MODE_ALLOC && res.status == STATUS_OK) begin
      live_handles.insert(live_handles.size(), res.handle);
    end
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // every result strobe is matched against the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed, expected none actual handle %0h status %0d",
                 $time, handle_out_o, status_o);
        fail_count++;
      end else begin
        alloc_result_t want;
        want = owed_results[0];
        owed_results.delete(0);
        check_field("handle_out", want.handle, handle_out_o);
        check_field("slot_index", 32'(want.slot), 32'(slot_index_o));
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("avatar_total", 32'(want.avatars), 32'(avatar_total_o));
        check_field("highest_slot", 32'(want.highest), 32'(highest_slot_o));
        case (want.status)
          STATUS_EMPTY: seen_empty++;
          STATUS_FULL:  seen_full++;
          default: begin
            if (want.handle != '0 || want.slot != '0 || want.avatars != '0) begin
              if (want.handle != '0) seen_alloc++;
              else seen_free++;
            end else begin
              seen_free++;
            end
          end
        endcase
      end
    end
  end

  // oldest handle still held, taken out of the live list
  function automatic logic [31:0] take_oldest_live();
    logic [31:0] h;
    h = live_handles[0];
    live_handles.delete(0);
    return h;
  endfunction

  // pick a random live handle to return; a foreign one if none is held, and in 15 of 100 draws otherwise
  function automatic logic [31:0] pick_victim();
    int k;
    logic [31:0] h;
    if (live_handles.size() == 0 || $urandom_range(0, 99) < 15) return $urandom;
    k = $urandom_range(0, live_handles.size() - 1);
    h = live_handles[k];
    live_handles.delete(k);
    return h;
  endfunction

  // free into the pool that reset left full, avatar count already at zero
  task automatic test_free_when_full();
    alloc_result_t r;
    send_word(MODE_FREE, 8'h00, 1'b1, 32'hFFFF_FFFF, r);
    send_word(MODE_FREE, 8'hFF, 1'b0, 32'h0000_0000, r);
  endtask

  // type extremes, avatar up and down, foreign handles and avatar underflow
  task automatic test_alloc_free_basics();
    alloc_result_t r;
    send_word(MODE_ALLOC, 8'h00, 1'b0, 32'h0, r);
    send_word(MODE_ALLOC, 8'hFF, 1'b1, 32'hFFFF_FFFF, r);
    send_word(MODE_ALLOC, 8'h5A, 1'b1, 32'h0, r);
    send_word(MODE_ALLOC, 8'hA5, 1'b0, 32'h0, r);
    send_word(MODE_FREE, 8'h00, 1'b1, 32'hFFFF_FFFF, r);
    send_word(MODE_FREE, 8'hFF, 1'b1, 32'h0000_0000, r);
    // avatar count is zero here, so this one must stay at zero
    send_word(MODE_FREE, 8'h00, 1'b1, take_oldest_live(), r);
    send_word(MODE_FREE, 8'h00, 1'b0, take_oldest_live(), r);
  endtask

  // take every handle, then ask twice more from the empty pool
  task automatic test_drain_to_empty();
    alloc_result_t r;
    gaps_on = 1'b0;
    while (pool_fill != 0) send_word(MODE_ALLOC, 8'($urandom), 1'b0, $urandom, r);
    gaps_on = 1'b1;
    send_word(MODE_ALLOC, 8'hFF, 1'b1, 32'h0, r);
    send_word(MODE_ALLOC, 8'h00, 1'b0, 32'h0, r);
  endtask

  // generation at its top value must wrap to zero on the next allocate
  task automatic test_generation_wrap();
    alloc_result_t r;
    send_word(MODE_FREE, 8'h00, 1'b0, {8'hFF, 14'h3FFF, 10'h155}, r);
    send_word(MODE_ALLOC, 8'h3C, 1'b0, 32'h0, r);
    send_word(MODE_FREE, 8'h00, 1'b0, {8'h00, 14'h3FFE, 10'h2AA}, r);
    send_word(MODE_ALLOC, 8'hC3, 1'b0, 32'h0, r);
  endtask

  // mostly well-formed alloc and free traffic, phases bias the pool level
  task automatic test_random_traffic(input int count);
    alloc_result_t r;
    int alloc_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       alloc_pct = 85;
          1:       alloc_pct = 15;
          default: alloc_pct = 50;
        endcase
        // some phases run with no idling at all
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < alloc_pct)
        send_word(MODE_ALLOC, 8'($urandom), 1'($urandom), $urandom, r);
      else
        send_word(MODE_FREE, 8'($urandom), 1'($urandom), pick_victim(), r);
    end
    gaps_on = 1'b1;
  endtask

  // drop start and run out the owed results, then let the block idle
  task automatic wait_for_drain();
    start = 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainLat) @(posedge clk_i);
  endtask

  // stimulus and final verdict
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    mode_i       = MODE_ALLOC;
    actor_type_i = '0;
    is_avatar_i  = 1'b0;
    handle_in_i  = '0;
    fail_count   = 0;
    words_sent   = 0;
    seen_alloc   = 0;
    seen_free    = 0;
    seen_empty   = 0;
    seen_full    = 0;
    gaps_on      = 1'b1;
    reset_shadow();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_free_when_full();
    test_alloc_free_basics();
    test_drain_to_empty();
    test_generation_wrap();
    test_random_traffic(110);
    wait_for_drain();

    $display("covered %0d words: %0d good allocs, %0d good frees, %0d empty, %0d full",
             words_sent, seen_alloc, seen_free, seen_empty, seen_full);
    $display("frees into a full pool, drain to empty, generation wrap and avatar floor exercised");
    if (fail_count == 0) begin
      $display("generational_id_allocator_unit regression: pass");
    end else begin
      $display("generational_id_allocator_unit regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(12 * 400_000);
    $display("%0t: watchdog expired with %0d results owed", $time, owed_results.size());
    $display("generational_id_allocator_unit regression: fail");
    $finish;
  end

endmodule

/* files.f */
src/gia_pkg.sv
src/gia_ram.sv
src/generational_id_allocator_unit.sv
test/tb.sv
